// ===== rtl/adsr_envelope_generator_top_assert.svh =====
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked after reset
`define ADSR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adsr envelope check failed");

// next-cycle implication, checked after reset
`define ADSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adsr envelope check failed");

`endif

// ===== rtl/adsr_pkg.sv =====
package adsr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LVL_W     = FRAC_BITS + 2;
    localparam int SUS_W     = FRAC_BITS + 1;
    localparam int FAC_W     = 16;
    localparam int CNT_W     = 24;
    localparam int STAGE_W   = 3;
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam int IN_TDATA_W  = ((SUS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LVL_W + STAGE_W + 7) / 8) * 8;

    localparam int MUL_AW = LVL_W + 1;
    localparam int MUL_BW = SUS_W;
    localparam int PROD_W = MUL_AW + MUL_BW;

    localparam logic [SUS_W-1:0] LVL_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LVL_W-1:0] LVL_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
    localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
    localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
    localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_SET_SUS = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CUTOFF  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd5;

    localparam logic [FAC_W-1:0] RST_ATTACK  = 16'd655;
    localparam logic [FAC_W-1:0] RST_DECAY   = 16'd33;
    localparam logic [SUS_W-1:0] RST_SUSTAIN = 17'd32768;
    localparam logic [FAC_W-1:0] RST_RELEASE = 16'd7;
    localparam logic [FAC_W-1:0] RST_CUTOFF  = 16'd1;
    localparam logic [CNT_W-1:0] RST_TIMEOUT = 24'd1920000;

endpackage

// ===== rtl/adsr_envelope_generator_top.sv =====
// Sequence: an accepted input goes to SETUP; idle and attack ticks and control events
// then go to FINISH, sustain and release ticks pass once through MUL1 and PROD1, and
// decay ticks also through MUL2 and PROD2 unless their first product reaches one. FINISH
// waits while a stalled result is held; no new input is taken until it is done. Passes
// through the one shared multiplier: decay up to two, sustain and release one, attack none.
// Reset: rst_n is asynchronous, active low; it idles the voice, clears level, tick
// count and sustain target, and loads the configuration registers with defaults.
module adsr_envelope_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [adsr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [16:0] sustain_value
    input  logic [adsr_pkg::OP_W-1:0]           s_tuser,   // [1:0] opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adsr_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [17:0] level, [20:18] stage
    output logic                                m_tlast,   // ended
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [adsr_pkg::ADDR_W-1:0]         paddr,
    input  logic [adsr_pkg::DATA_W-1:0]         pwdata,
    output logic [adsr_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_PROD1  = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_PROD2  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    localparam int PHI_W = adsr_pkg::PROD_W - adsr_pkg::FRAC_BITS;

    function automatic logic [adsr_pkg::SUS_W-1:0] clamp_one(
        input logic [adsr_pkg::SUS_W-1:0] v
    );
        return (v > adsr_pkg::LVL_ONE) ? adsr_pkg::LVL_ONE : v;
    endfunction

    logic [adsr_pkg::FAC_W-1:0]   attack_step_reg;
    logic [adsr_pkg::FAC_W-1:0]   decay_factor_reg;
    logic [adsr_pkg::SUS_W-1:0]   sustain_default_reg;
    logic [adsr_pkg::FAC_W-1:0]   release_factor_reg;
    logic [adsr_pkg::FAC_W-1:0]   cutoff_level_reg;
    logic [adsr_pkg::CNT_W-1:0]   timeout_ticks_reg;

    logic                            cfg_write;
    logic [adsr_pkg::REG_IDX_W-1:0]  cfg_index;

    logic [2:0]                      state_reg, state_next;
    logic [adsr_pkg::OP_W-1:0]       op_reg, op_next;
    logic [adsr_pkg::SUS_W-1:0]      sv_reg, sv_next;
    logic [adsr_pkg::LVL_W-1:0]      y_reg, y_next;
    logic                            dir_reg, dir_next;
    logic [adsr_pkg::MUL_AW-1:0]     mul_a_reg, mul_a_next;
    logic [adsr_pkg::MUL_BW-1:0]     mul_b_reg, mul_b_next;
    logic [adsr_pkg::PROD_W-1:0]     prod_reg;

    logic [adsr_pkg::LVL_W-1:0]      amp_reg, amp_next;
    logic [adsr_pkg::STAGE_W-1:0]    phase_reg, phase_next;
    logic [adsr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [adsr_pkg::SUS_W-1:0]      target_reg, target_next;

    logic                            m_tvalid_reg, m_tvalid_next;
    logic [adsr_pkg::LVL_W-1:0]      out_level_reg, out_level_next;
    logic [adsr_pkg::STAGE_W-1:0]    out_stage_reg, out_stage_next;
    logic                            out_ended_reg, out_ended_next;

    logic [adsr_pkg::LVL_W:0]        attack_sum;
    logic [adsr_pkg::LVL_W-1:0]      target_ext;
    logic                            sus_up;
    logic [adsr_pkg::LVL_W-1:0]      sus_diff;
    logic [adsr_pkg::LVL_W-1:0]      prod_lvl;
    logic [PHI_W-1:0]                prod_hi;

    logic [adsr_pkg::LVL_W-1:0]      fin_amp;
    logic [adsr_pkg::STAGE_W-1:0]    fin_phase;
    logic [adsr_pkg::CNT_W-1:0]      fin_count;
    logic [adsr_pkg::SUS_W-1:0]      fin_target;
    logic [adsr_pkg::LVL_W-1:0]      fin_level;
    logic                            fin_ended;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = paddr[adsr_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg     <= adsr_pkg::RST_ATTACK;
            decay_factor_reg    <= adsr_pkg::RST_DECAY;
            sustain_default_reg <= adsr_pkg::RST_SUSTAIN;
            release_factor_reg  <= adsr_pkg::RST_RELEASE;
            cutoff_level_reg    <= adsr_pkg::RST_CUTOFF;
            timeout_ticks_reg   <= adsr_pkg::RST_TIMEOUT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                adsr_pkg::REG_ATTACK:  attack_step_reg     <= pwdata[adsr_pkg::FAC_W-1:0];
                adsr_pkg::REG_DECAY:   decay_factor_reg    <= pwdata[adsr_pkg::FAC_W-1:0];
                adsr_pkg::REG_SUSTAIN: sustain_default_reg <= pwdata[adsr_pkg::SUS_W-1:0];
                adsr_pkg::REG_RELEASE: release_factor_reg  <= pwdata[adsr_pkg::FAC_W-1:0];
                adsr_pkg::REG_CUTOFF:  cutoff_level_reg    <= pwdata[adsr_pkg::FAC_W-1:0];
                adsr_pkg::REG_TIMEOUT: timeout_ticks_reg   <= pwdata[adsr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::DATA_W'(attack_step_reg);
            adsr_pkg::REG_DECAY:   prdata = adsr_pkg::DATA_W'(decay_factor_reg);
            adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::DATA_W'(sustain_default_reg);
            adsr_pkg::REG_RELEASE: prdata = adsr_pkg::DATA_W'(release_factor_reg);
            adsr_pkg::REG_CUTOFF:  prdata = adsr_pkg::DATA_W'(cutoff_level_reg);
            adsr_pkg::REG_TIMEOUT: prdata = adsr_pkg::DATA_W'(timeout_ticks_reg);
            default:               prdata = '0;
        endcase
    end

    assign attack_sum = (adsr_pkg::LVL_W + 1)'(amp_reg) + (adsr_pkg::LVL_W + 1)'(attack_step_reg);
    assign target_ext = adsr_pkg::LVL_W'(target_reg);
    assign sus_up     = target_ext >= amp_reg;
    assign sus_diff   = sus_up ? (target_ext - amp_reg) : (amp_reg - target_ext);
    assign prod_lvl   = prod_reg[adsr_pkg::FRAC_BITS +: adsr_pkg::LVL_W];
    assign prod_hi    = prod_reg[adsr_pkg::PROD_W-1:adsr_pkg::FRAC_BITS];

    // stage transitions, cutoff and event effects for the finishing step
    always_comb
    begin
        fin_amp    = amp_reg;
        fin_phase  = phase_reg;
        fin_count  = count_reg;
        fin_target = target_reg;
        fin_ended  = 1'b0;
        fin_level  = amp_reg;
        unique case (op_reg)
            adsr_pkg::OP_TICK:
            begin
                if (phase_reg != adsr_pkg::ST_IDLE)
                begin
                    unique case (phase_reg)
                        adsr_pkg::ST_ATTACK:
                        begin
                            if (decay_factor_reg != '0)
                            begin
                                if (y_reg >= adsr_pkg::LVL_W'(adsr_pkg::LVL_ONE))
                                    fin_phase = adsr_pkg::ST_DECAY;
                            end
                            else if (y_reg >= target_ext)
                                fin_phase = adsr_pkg::ST_SUSTAIN;
                        end
                        adsr_pkg::ST_DECAY:
                        begin
                            if (y_reg <= target_ext)
                                fin_phase = adsr_pkg::ST_SUSTAIN;
                        end
                        adsr_pkg::ST_SUSTAIN:
                        begin
                            if (count_reg > timeout_ticks_reg)
                                fin_phase = adsr_pkg::ST_RELEASE;
                        end
                        default: fin_phase = adsr_pkg::ST_RELEASE;
                    endcase
                    if (count_reg != adsr_pkg::CNT_MAX)
                        fin_count = count_reg + 1'b1;
                    if (fin_phase >= adsr_pkg::ST_DECAY
                        && y_reg < adsr_pkg::LVL_W'(cutoff_level_reg))
                    begin
                        fin_phase = adsr_pkg::ST_IDLE;
                        fin_ended = 1'b1;
                    end
                    fin_level = y_reg;
                    fin_amp   = (fin_phase == adsr_pkg::ST_IDLE) ? '0 : y_reg;
                end
                else
                begin
                    fin_level = '0;
                    fin_amp   = '0;
                end
            end
            adsr_pkg::OP_NOTE_ON:
            begin
                fin_amp    = '0;
                fin_phase  = adsr_pkg::ST_ATTACK;
                fin_count  = '0;
                fin_target = clamp_one(sustain_default_reg);
                fin_level  = '0;
            end
            adsr_pkg::OP_RELEASE:
            begin
                if (phase_reg != adsr_pkg::ST_IDLE)
                    fin_phase = adsr_pkg::ST_RELEASE;
                else
                begin
                    fin_level = '0;
                    fin_amp   = '0;
                end
            end
            default:
            begin
                if (phase_reg != adsr_pkg::ST_IDLE)
                    fin_target = clamp_one(sv_reg);
                else
                begin
                    fin_level = '0;
                    fin_amp   = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        sv_next        = sv_reg;
        y_next         = y_reg;
        dir_next       = dir_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        amp_next       = amp_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        target_next    = target_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        out_level_next = out_level_reg;
        out_stage_next = out_stage_reg;
        out_ended_next = out_ended_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    sv_next    = s_tdata[adsr_pkg::SUS_W-1:0];
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_FINISH;
                y_next     = amp_reg;
                if (op_reg == adsr_pkg::OP_TICK)
                begin
                    unique case (phase_reg)
                        adsr_pkg::ST_IDLE: ;
                        adsr_pkg::ST_ATTACK:
                            y_next = attack_sum[adsr_pkg::LVL_W] ? adsr_pkg::LVL_MAX
                                                                 : attack_sum[adsr_pkg::LVL_W-1:0];
                        adsr_pkg::ST_DECAY:
                        begin
                            mul_a_next = adsr_pkg::MUL_AW'(amp_reg)
                                       + adsr_pkg::MUL_AW'(adsr_pkg::LVL_ONE);
                            mul_b_next = adsr_pkg::MUL_BW'(decay_factor_reg);
                            state_next = S_MUL1;
                        end
                        adsr_pkg::ST_SUSTAIN:
                        begin
                            dir_next   = sus_up;
                            mul_a_next = adsr_pkg::MUL_AW'(sus_diff);
                            mul_b_next = adsr_pkg::MUL_BW'(release_factor_reg);
                            state_next = S_MUL1;
                        end
                        default:
                        begin
                            mul_a_next = adsr_pkg::MUL_AW'(amp_reg);
                            mul_b_next = adsr_pkg::LVL_ONE
                                       - adsr_pkg::MUL_BW'(release_factor_reg);
                            state_next = S_MUL1;
                        end
                    endcase
                end
            end
            S_MUL1:
                state_next = S_PROD1;
            S_PROD1:
            begin
                state_next = S_FINISH;
                unique case (phase_reg)
                    adsr_pkg::ST_DECAY:
                    begin
                        if (prod_hi >= PHI_W'(adsr_pkg::LVL_ONE))
                            y_next = '0;
                        else
                        begin
                            mul_a_next = adsr_pkg::MUL_AW'(amp_reg);
                            mul_b_next = adsr_pkg::LVL_ONE - prod_hi[adsr_pkg::SUS_W-1:0];
                            state_next = S_MUL2;
                        end
                    end
                    adsr_pkg::ST_SUSTAIN:
                        y_next = dir_reg ? (amp_reg + prod_lvl) : (amp_reg - prod_lvl);
                    default:
                        y_next = prod_lvl;
                endcase
            end
            S_MUL2:
                state_next = S_PROD2;
            S_PROD2:
            begin
                y_next     = prod_lvl;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    amp_next       = fin_amp;
                    phase_next     = fin_phase;
                    count_next     = fin_count;
                    target_next    = fin_target;
                    out_level_next = fin_level;
                    out_stage_next = fin_phase;
                    out_ended_next = fin_ended;
                    m_tvalid_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            amp_reg      <= '0;
            phase_reg    <= adsr_pkg::ST_IDLE;
            count_reg    <= '0;
            target_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            amp_reg      <= amp_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            target_reg   <= target_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sv_reg        <= sv_next;
        y_reg         <= y_next;
        dir_reg       <= dir_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        prod_reg      <= adsr_pkg::PROD_W'(mul_a_reg) * adsr_pkg::PROD_W'(mul_b_reg);
        out_level_reg <= out_level_next;
        out_stage_reg <= out_stage_next;
        out_ended_reg <= out_ended_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = adsr_pkg::OUT_TDATA_W'({out_stage_reg, out_level_reg});
    assign m_tlast  = out_ended_reg;

endmodule

// ===== rtl/adsr_checker.sv =====
`include "adsr_envelope_generator_top_assert.svh"

module adsr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [adsr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    logic [adsr_pkg::LVL_W-1:0]   out_level;
    logic [adsr_pkg::STAGE_W-1:0] out_stage;

    assign out_level = m_tdata[adsr_pkg::LVL_W-1:0];
    assign out_stage = m_tdata[adsr_pkg::LVL_W +: adsr_pkg::STAGE_W];

    // an ending result always reports the idle stage
    `ADSR_ASSERT_SAME(ended_is_idle, m_tvalid && m_tlast, out_stage == adsr_pkg::ST_IDLE)
    // an idle voice that did not just end reports a zero level
    `ADSR_ASSERT_SAME(idle_level_zero, m_tvalid && !m_tlast && out_stage == adsr_pkg::ST_IDLE, out_level == '0)
    // one item at a time: no input transfer right after another
    `ADSR_ASSERT_NEXT(busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a stalled result holds
    `ADSR_ASSERT_NEXT(result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind adsr_envelope_generator_top adsr_checker u_adsr_checker (.*);
